/* rtl/maf_pkg.sv */
// maf_pkg: shared widths, reset values and controller/datapath command type
// for the moving average filter; no dependencies
`default_nettype none

package maf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int SUM_W          = 22;
  localparam int WIN_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int DIV_CNT_W      = $clog2(SUM_W);
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(50);

  // register index taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic capture;   // latch request sample, read ring at write index
    logic update;    // update sum, ring and index, load divider
    logic div_step;  // one quotient bit
    logic load_out;  // move saturated quotient to output register
  } dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/maf_ctrl.sv */
// maf_ctrl: sequencing state machine and output valid flag
// depends on maf_pkg (command struct, divider count width)
`default_nettype none

module maf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output maf_pkg::dp_cmd_t     cmd
);
  import maf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(SUM_W - 1);

  logic [1:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/maf_datapath.sv */
// maf_datapath: sample ring memory, running sum, write index, bit-serial
// divider and output register; depends on maf_pkg
`default_nettype none

module maf_datapath #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire maf_pkg::dp_cmd_t                  cmd,
  input  wire logic [maf_pkg::WIN_W-1:0]         win_len,
  input  wire logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  output logic signed [maf_pkg::SAMPLE_W-1:0]    out_average
);
  import maf_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CMP_W = (IDX_W + 1 > WIN_W) ? IDX_W + 1 : WIN_W;
  localparam logic [SUM_W-1:0] POS_MAX = SUM_W'(32767);
  localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(32768);

  logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [WIN_W-1:0]    eff_win;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SUM_W-1:0]    sum_abs;

  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [WIN_W-1:0]    rem_r, rem_nxt;
  logic [WIN_W-1:0]    dvs_r;
  logic                neg_r;
  logic [WIN_W:0]      rem_sh, rem_diff;
  logic [SAMPLE_W-1:0] avg_sat;
  logic [SAMPLE_W-1:0] out_average_r;

  // effective window: zero acts as one, clamp to ring depth
  always_comb begin
    eff_win = win_len;
    if (win_len == '0) begin
      eff_win = WIN_W'(1);
    end else if (int'(win_len) > MAX_WINDOW) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end
  end

  assign old_sample = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    sum_nxt = sum_r
            + {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r}
            - {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample};
    sum_abs = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;
    if ((CMP_W'(idx_r) + CMP_W'(1)) >= CMP_W'(eff_win)) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // restoring division step
  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_diff[WIN_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[WIN_W-1:0];
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (!neg_r) begin
      avg_sat = (quo_r > POS_MAX) ? SAMPLE_W'(16'h7fff) : quo_r[SAMPLE_W-1:0];
    end else begin
      avg_sat = (quo_r > NEG_MAX) ? SAMPLE_W'(16'h8000)
                                  : (~quo_r[SAMPLE_W-1:0] + 1'b1);
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= ring_mem[idx_r];
    end
    if (cmd.update) begin
      ring_mem[idx_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      sum_r    <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.capture) begin
        rd_vld_r <= vld_r[idx_r];
      end
      if (cmd.update) begin
        vld_r[idx_r] <= 1'b1;
        sum_r        <= sum_nxt;
        idx_r        <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
    end
    if (cmd.update) begin
      quo_r <= sum_abs;
      rem_r <= '0;
      dvs_r <= eff_win;
      neg_r <= sum_nxt[SUM_W-1];
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      out_average_r <= avg_sat;
    end
  end

  assign out_average = out_average_r;

endmodule

`default_nettype wire

/* rtl/moving_average_filter.sv */
// moving_average_filter: boxcar average over a configurable window;
// one request at a time: in_ready is high only in idle, and each request runs capture,
// update, the 22-step bit-serial divider and the output load before the next is accepted;
// the output load waits while a previous average waits on out_ready
// reset (synchronous, rst_n low) clears sum, write index and ring valid flags
// at once, no clearing pass; window_length resets to 50
// depends on maf_pkg, maf_ctrl, maf_datapath
`default_nettype none

module moving_average_filter #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [maf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [maf_pkg::SAMPLE_W-1:0]       out_average,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [maf_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [maf_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [maf_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                      pready
);
  import maf_pkg::*;

  logic [WIN_W-1:0] win_r;
  logic             reg_sel;
  dp_cmd_t          cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      win_r <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(APB_DATA_W-WIN_W){1'b0}}, win_r};
    end
  end

  maf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  maf_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .win_len     (win_r),
    .in_sample   (in_sample),
    .out_average (out_average)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for moving_average_filter: directed table then phased random samples,
// each average checked against a typed value or a boxcar predictor kept in step with the dut
// depends on maf_pkg and moving_average_filter
`timescale 1ns / 100ps

module testbench;

  import maf_pkg::*;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WINDOW, ROW_UNMAPPED} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    int        value;
    bit        typed;
    int        average;
  } stim_row_t;

  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR   = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_WINDOW_LENGTH, 2'b00};
  localparam int MAX_WIN = MAX_WINDOW_DEF;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 170;
  localparam int PHASE_WINDOW [PHASES] = '{64, 1, 0, 127, 2, 65, 63, -1, -1, 50, -1, 1};

  localparam stim_row_t DIRECTED [29] = '{
    '{ROW_WINDOW, 1, 0, 0},
    '{ROW_SAMPLE, 32767, 1, 32767},
    '{ROW_SAMPLE, -32768, 1, -32768},
    '{ROW_SAMPLE, 0, 1, 0},
    '{ROW_WINDOW, 0, 0, 0},
    '{ROW_SAMPLE, 21845, 1, 21845},
    '{ROW_SAMPLE, -1, 1, -1},
    '{ROW_WINDOW, 127, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0},
    '{ROW_UNMAPPED, 2, 0, 0},
    '{ROW_SAMPLE, -21846, 0, 0},
    '{ROW_WINDOW, 1, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0},
    '{ROW_SAMPLE, 100, 0, 0},
    '{ROW_WINDOW, 64, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0},
    '{ROW_WINDOW, 65, 0, 0},
    '{ROW_SAMPLE, 1, 0, 0},
    '{ROW_WINDOW, 1, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0},
    '{ROW_WINDOW, 2, 0, 0},
    '{ROW_SAMPLE, 7, 0, 0},
    '{ROW_SAMPLE, -7, 0, 0},
    '{ROW_SAMPLE, 0, 0, 0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   in_sample;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [SAMPLE_W-1:0]   out_average;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [APB_ADDR_W-1:0]        paddr;
  logic [APB_DATA_W-1:0]        pwdata;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;

  // boxcar state mirrored from the dut
  logic signed [SAMPLE_W-1:0]   avg_ring [MAX_WIN];
  logic [SUM_W-1:0]             avg_sum;
  int                           avg_index;
  logic [WIN_W-1:0]             avg_window;

  logic signed [SAMPLE_W-1:0]   expected_averages [$];
  logic signed [SAMPLE_W-1:0]   expected_head;
  int                           mismatches;
  bit                           calm;

  moving_average_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_average(out_average),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [SAMPLE_W-1:0] predict_average(
    input logic signed [SAMPLE_W-1:0] s
  );
    int n;
    int slot;
    int total;
    int q;
    n = (avg_window == 0) ? 1 : (avg_window > MAX_WIN) ? MAX_WIN : int'(avg_window);
    slot = (avg_index >= MAX_WIN) ? 0 : avg_index;
    total = int'($signed(avg_sum)) + int'(s) - int'(avg_ring[slot]);
    avg_sum = SUM_W'(total);
    avg_ring[slot] = s;
    slot++;
    if (slot >= n) slot = 0;
    avg_index = slot;
    q = int'($signed(avg_sum)) / n;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return SAMPLE_W'(q);
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                             input logic signed [SAMPLE_W-1:0] typed_avg);
    logic signed [SAMPLE_W-1:0] predicted;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    predicted = predict_average(s);
    expected_averages.push_back(typed ? typed_avg : predicted);
    @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    wait_idle();
    apb_transfer(1'b1, addr, value, readback);
    if (addr == WINDOW_ADDR) avg_window = value[WIN_W-1:0];
    apb_transfer(1'b0, WINDOW_ADDR, '0, readback);
    if (readback !== APB_DATA_W'(avg_window)) begin
      mismatches++;
      $display("%0t: window_length readback mismatch, expected %0d, got %0d",
               $time, avg_window, readback);
    end
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        mismatches++;
        $display("%0t: average mismatch, expected none, got %0d", $time, out_average);
      end else begin
        expected_head = expected_averages.pop_front();
        if (out_average !== expected_head) begin
          mismatches++;
          $display("%0t: average mismatch, expected %0d, got %0d",
                   $time, expected_head, out_average);
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int win;
    int pick;
    logic signed [SAMPLE_W-1:0] s;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    calm       = 1'b0;
    avg_sum    = '0;
    avg_index  = 0;
    avg_window = WIN_RESET;
    foreach (avg_ring[i]) avg_ring[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        ROW_SAMPLE: begin
          send_sample(SAMPLE_W'(DIRECTED[i].value), DIRECTED[i].typed,
                      SAMPLE_W'(DIRECTED[i].average));
        end
        ROW_WINDOW: begin
          write_register(WINDOW_ADDR, APB_DATA_W'(DIRECTED[i].value));
        end
        default: begin
          write_register(UNMAPPED_ADDR, APB_DATA_W'(DIRECTED[i].value));
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      win = (PHASE_WINDOW[p] < 0) ? int'($urandom_range(127)) : PHASE_WINDOW[p];
      write_register(WINDOW_ADDR, APB_DATA_W'(win));
      calm = (p == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(9);
        // first phase fills the full ring with large values so the next
        // shrink to one sample drives the average into saturation
        if (p == 0 && pick < 5) s = 16'sh7FFF;
        else if (pick == 0) s = 16'sh7FFF;
        else if (pick == 1) s = 16'sh8000;
        else if (pick == 2) s = SAMPLE_W'(int'($urandom_range(8)) - 4);
        else s = SAMPLE_W'($urandom);
        send_sample(s, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
